### hw/rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants, register map and segment decode for the scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned DigitFields = 4;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned SegW        = 8;
  localparam int unsigned EnableW     = 4;
  localparam int unsigned DotW        = 8;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [SegW-1:0] DpBit      = 8'h01;
  localparam logic [DotW-1:0] DotReset   = 8'hFF;

  // register index taken from the word address bit
  typedef enum logic {
    RegDotPosition = 1'b0,
    RegBlankZeros  = 1'b1
  } reg_idx_e;

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [SegW-1:0]   seg_t;

  // segment byte: bit7 a down to bit1 g, bit0 point; codes above nine show nothing
  function automatic seg_t seg_decode(input digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'b11111100;
      4'd1:    s = 8'b01100000;
      4'd2:    s = 8'b11011010;
      4'd3:    s = 8'b11110010;
      4'd4:    s = 8'b01100110;
      4'd5:    s = 8'b10110110;
      4'd6:    s = 8'b10111110;
      4'd7:    s = 8'b11100000;
      4'd8:    s = 8'b11111110;
      4'd9:    s = 8'b11110110;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/ssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_if
// Valid/ready channels of the scan driver: digit word in, segment word out.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  import ssd_pkg::*;

  logic   valid;
  logic   ready;
  digit_t digit_0;
  digit_t digit_1;
  digit_t digit_2;
  digit_t digit_3;

  modport source (output valid, digit_0, digit_1, digit_2, digit_3, input ready);
  modport sink   (input valid, digit_0, digit_1, digit_2, digit_3, output ready);
endinterface

interface ssd_out_if;
  import ssd_pkg::*;

  logic               valid;
  logic               ready;
  seg_t               segments;
  logic [EnableW-1:0] digit_enable;

  modport source (output valid, segments, digit_enable, input ready);
  modport sink   (input valid, segments, digit_enable, output ready);
endinterface

### hw/rtl/seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed seven-segment scan: one displayed position per refresh word.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one refresh word per tick: four decimal digits, digit_0
//   least significant. Each accepted word advances the scan index (wrapping
//   modulo NUM_DIGITS, so the first word after reset shows position 1) and
//   yields one word on out_o: the segment byte of the digit at that position,
//   with the decimal point when the index equals dot_position, and a one-hot
//   digit enable. With blank_leading_zeros set, a leading zero above position
//   0 gives no segments and no enable. Positions 4 and up decode as zero and get no enable.
//   An accepted word passes through the input register and then the result
//   register to out_o. While the receiver does not stall, a word may be
//   accepted every cycle; the rate is one word per cycle, with a
//   combinational decode between the two registers.
//   When the receiver stalls, both stages hold and in_i.ready falls once the
//   input register is full and cannot move on.
//   Reset clears the scan index and both valid flags, sets dot_position to
//   255 (no point) and blank_leading_zeros to 0. The APB port at byte 0 and 4
//   holds the two registers; pready is always high.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ssd_in_if.sink                    in_i,
  ssd_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ssd_pkg::ApbAddrW-1:0] paddr,
  input  logic [ssd_pkg::ApbDataW-1:0] pwdata,
  output logic [ssd_pkg::ApbDataW-1:0] prdata,
  output logic                      pready
);
  import ssd_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_DIGITS);

  // configuration registers
  logic [DotW-1:0] dot_q;
  logic            blank_q;
  reg_idx_e        reg_sel;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= DotReset;
      blank_q <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        RegDotPosition: dot_q   <= pwdata[DotW-1:0];
        RegBlankZeros:  blank_q <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegDotPosition: prdata = {{(ApbDataW-DotW){1'b0}}, dot_q};
      RegBlankZeros:  prdata = {{(ApbDataW-1){1'b0}}, blank_q};
      default:        prdata = '0;
    endcase
  end

  // scan index and handshake
  logic [IdxW-1:0] idx_q, idx_d;
  logic            s1_valid_q;
  logic            out_valid_q;
  logic            s1_advance;
  logic            in_fire;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;
  assign in_fire    = in_i.valid && in_i.ready;
  assign idx_d      = (idx_q == IdxW'(NUM_DIGITS - 1)) ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        idx_q <= idx_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (!out_valid_q || out_o.ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // input register
  digit_t          s1_digit_q [DigitFields];
  logic [IdxW-1:0] s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_digit_q[0] <= in_i.digit_0;
      s1_digit_q[1] <= in_i.digit_1;
      s1_digit_q[2] <= in_i.digit_2;
      s1_digit_q[3] <= in_i.digit_3;
      s1_idx_q      <= idx_d;
    end
  end

  // decode: digits beyond the four fields read as zero
  digit_t             digit_ext [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] nonzero;
  logic [EnableW-1:0] enable_d;

  for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_pos
    if (p < DigitFields) begin : g_field
      assign digit_ext[p] = s1_digit_q[p];
    end else begin : g_none
      assign digit_ext[p] = '0;
    end
    assign nonzero[p] = (digit_ext[p] != '0);
  end

  for (genvar b = 0; b < EnableW; b++) begin : g_en
    if (b < NUM_DIGITS) begin : g_live
      assign enable_d[b] = (s1_idx_q == IdxW'(b));
    end else begin : g_dead
      assign enable_d[b] = 1'b0;
    end
  end

  digit_t             cur_digit;
  logic               higher_nz;
  logic               blanked;
  seg_t               seg_d;
  seg_t               seg_q;
  logic [EnableW-1:0] enable_q;

  assign cur_digit = digit_ext[s1_idx_q];
  // any nonzero digit strictly above the shown position
  assign higher_nz = (((nonzero >> s1_idx_q) >> 1) != '0);
  assign blanked   = blank_q && (s1_idx_q != '0) && (cur_digit == '0) && !higher_nz;

  always_comb begin
    seg_d = seg_decode(cur_digit);
    if (DotW'(s1_idx_q) == dot_q) begin
      seg_d = seg_d | DpBit;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      seg_q    <= blanked ? '0 : seg_d;
      enable_q <= blanked ? '0 : enable_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.segments     = seg_q;
  assign out_o.digit_enable = enable_q;

endmodule
